// ===== rtl/core/humidity_sensor_poll_sequencer_assert.svh =====
// Assertion macros for the humidity sensor poll sequencer.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef HUMIDITY_SENSOR_POLL_SEQUENCER_ASSERT_SVH
`define HUMIDITY_SENSOR_POLL_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define HSPS_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define HSPS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define HSPS_ASSERT_NOW(label, pre, post, msg)
`define HSPS_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== rtl/core/hsps_pkg.sv =====
// Shared types and constants of the humidity sensor poll sequencer.
// No dependencies; used by all modules of the block.
package hsps_pkg;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_XFER    = 2'd2;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_UPDATE = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    localparam logic [1:0] CFG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_UPDATE_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_INIT_DELAY      = 2'd2;
    localparam logic [1:0] CFG_MEASURE_DELAY   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd68;
    localparam logic [15:0] RST_DELAY          = 16'd20;
    localparam logic [15:0] SOFT_RESET_WORD    = 16'h30A2;
    localparam logic [15:0] MEASURE_WORD       = 16'h2C0D;

    typedef enum logic [1:0] {
        PH_INIT    = 2'd0,
        PH_MEASURE = 2'd1,
        PH_READ    = 2'd2,
        PH_UPDATE  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]  command;
        logic        transfer_ok;
        logic [47:0] read_data;
    } t_item;

    typedef struct packed {
        logic [1:0]  bus_request;
        logic [6:0]  bus_address;
        logic [15:0] bus_write_word;
        logic [1:0]  event_code;
        logic        request_accepted;
        logic [15:0] humidity_raw;
        logic [15:0] temperature_raw;
        logic        values_valid;
    } t_result;

    typedef struct packed {
        logic awaiting;
    } t_status;

endpackage

// ===== rtl/core/hsps_in_stage.sv =====
// Input register of the poll sequencer: holds one transaction until the core takes it.
// Depends on hsps_pkg for the item type.
module hsps_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hsps_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output hsps_pkg::t_item o_item
);

    logic            r_valid;
    hsps_pkg::t_item r_item;

    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/core/hsps_seq_core.sv =====
// Sequencer state, configuration registers and result logic of the poll sequencer.
// Depends on hsps_pkg for codes, phases and the item and result types.
module hsps_seq_core #(
    parameter int TIME_BITS   = 32,
    parameter int START_DELAY = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  hsps_pkg::t_item                  i_item,
    input  logic                             i_cfg_we,
    input  logic [hsps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hsps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output hsps_pkg::t_result                o_result,
    output hsps_pkg::t_status                o_status
);

    hsps_pkg::t_phase     r_phase, n_phase;
    logic                 r_pend, n_pend;
    logic [TIME_BITS-1:0] r_due, n_due;
    logic [TIME_BITS-1:0] r_ready, n_ready;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [31:0]          r_ivl_left, n_ivl_left;
    logic                 r_active, n_active;
    logic                 r_await, n_await;
    logic                 r_valid, n_valid;
    logic [15:0]          r_hum, n_hum;
    logic [15:0]          r_temp, n_temp;
    logic [6:0]           r_dev_addr, n_dev_addr;
    logic [31:0]          r_interval, n_interval;
    logic [15:0]          r_init_delay, n_init_delay;
    logic [15:0]          r_meas_delay, n_meas_delay;

    logic                 tick;
    logic                 xfer;
    logic                 iv_hit;
    logic                 pre_pend;
    logic                 pre_act;
    logic [TIME_BITS-1:0] pre_due;
    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] due_diff;
    logic                 task_go;

    // The interval counter may raise a measure request before the due check of the same tick.
    always_comb begin
        tick     = i_item.command == hsps_pkg::CMD_TICK;
        xfer     = (i_item.command == hsps_pkg::CMD_XFER) && r_await;
        time_inc = r_time + TIME_BITS'(1);
        iv_hit   = tick && (r_interval != 32'd0) && (r_ivl_left <= 32'd1);
        pre_act  = r_active || iv_hit;
        pre_pend = r_pend;
        pre_due  = r_due;
        if (iv_hit && !r_active) begin
            pre_pend = 1'b1;
            pre_due  = r_ready;
        end
        // Wrap-aware: the task is due when the difference lies in the lower half.
        due_diff = time_inc - pre_due;
        task_go  = tick && pre_pend && !r_await && !due_diff[TIME_BITS-1];
    end

    // Next state.
    always_comb begin
        n_phase      = r_phase;
        n_pend       = r_pend;
        n_due        = r_due;
        n_ready      = r_ready;
        n_time       = r_time;
        n_ivl_left   = r_ivl_left;
        n_active     = r_active;
        n_await      = r_await;
        n_valid      = r_valid;
        n_hum        = r_hum;
        n_temp       = r_temp;
        n_dev_addr   = r_dev_addr;
        n_interval   = r_interval;
        n_init_delay = r_init_delay;
        n_meas_delay = r_meas_delay;
        if (i_cfg_we) begin
            case (i_cfg_index)
                hsps_pkg::CFG_DEVICE_ADDRESS: begin
                    n_dev_addr = i_cfg_data[6:0];
                end
                hsps_pkg::CFG_UPDATE_INTERVAL: begin
                    n_interval = i_cfg_data;
                    n_ivl_left = i_cfg_data;
                    if (i_cfg_data != 32'd0 && !r_active) begin
                        n_active = 1'b1;
                        n_pend   = 1'b1;
                        n_due    = r_ready;
                    end
                end
                hsps_pkg::CFG_INIT_DELAY: begin
                    n_init_delay = i_cfg_data[15:0];
                end
                hsps_pkg::CFG_MEASURE_DELAY: begin
                    n_meas_delay = i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end else if (i_fire) begin
            case (i_item.command)
                hsps_pkg::CMD_TICK: begin
                    n_time   = time_inc;
                    n_pend   = pre_pend;
                    n_due    = pre_due;
                    n_active = pre_act;
                    if (r_interval != 32'd0) begin
                        n_ivl_left = iv_hit ? r_interval : r_ivl_left - 32'd1;
                    end
                    if (task_go) begin
                        n_pend = 1'b0;
                        case (r_phase)
                            hsps_pkg::PH_UPDATE: begin
                                n_active = 1'b0;
                                n_phase  = hsps_pkg::PH_MEASURE;
                            end
                            default: begin
                                n_await = 1'b1;
                            end
                        endcase
                    end
                end
                hsps_pkg::CMD_MEASURE: begin
                    if (!r_active) begin
                        n_active = 1'b1;
                        n_pend   = 1'b1;
                        n_due    = r_ready;
                    end
                end
                hsps_pkg::CMD_XFER: begin
                    if (r_await) begin
                        n_await = 1'b0;
                        if (!i_item.transfer_ok) begin
                            n_valid  = 1'b0;
                            n_active = 1'b0;
                            n_phase  = hsps_pkg::PH_INIT;
                            n_pend   = 1'b0;
                        end else begin
                            case (r_phase)
                                hsps_pkg::PH_INIT: begin
                                    n_phase = hsps_pkg::PH_MEASURE;
                                    n_ready = r_time + TIME_BITS'(r_init_delay);
                                    n_pend  = r_active;
                                    if (r_active) begin
                                        n_due = r_time + TIME_BITS'(r_init_delay);
                                    end
                                end
                                hsps_pkg::PH_MEASURE: begin
                                    n_phase = hsps_pkg::PH_READ;
                                    n_pend  = 1'b1;
                                    n_due   = r_time + TIME_BITS'(r_meas_delay);
                                end
                                default: begin
                                    // Read data: temperature in bytes 0 and 1,
                                    // humidity in bytes 3 and 4.
                                    n_temp   = i_item.read_data[47:32];
                                    n_hum    = i_item.read_data[23:8];
                                    n_valid  = 1'b1;
                                    n_active = 1'b0;
                                    n_phase  = hsps_pkg::PH_MEASURE;
                                    n_pend   = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result of the transaction being processed.
    always_comb begin
        o_result = '0;
        if (task_go && r_phase != hsps_pkg::PH_UPDATE) begin
            o_result.bus_address = r_dev_addr;
            case (r_phase)
                hsps_pkg::PH_INIT: begin
                    o_result.bus_request    = hsps_pkg::REQ_WRITE;
                    o_result.bus_write_word = hsps_pkg::SOFT_RESET_WORD;
                end
                hsps_pkg::PH_MEASURE: begin
                    o_result.bus_request    = hsps_pkg::REQ_WRITE;
                    o_result.bus_write_word = hsps_pkg::MEASURE_WORD;
                end
                default: begin
                    o_result.bus_request = hsps_pkg::REQ_READ;
                end
            endcase
        end
        if (task_go && r_phase == hsps_pkg::PH_UPDATE) begin
            o_result.event_code = hsps_pkg::EV_UPDATE;
        end else if (xfer && !i_item.transfer_ok) begin
            o_result.event_code = hsps_pkg::EV_ERROR;
        end else if (xfer && (r_phase == hsps_pkg::PH_READ || r_phase == hsps_pkg::PH_UPDATE)) begin
            o_result.event_code = hsps_pkg::EV_UPDATE;
        end
        o_result.request_accepted = (i_item.command == hsps_pkg::CMD_MEASURE) && !r_active;
        o_result.humidity_raw     = n_hum;
        o_result.temperature_raw  = n_temp;
        o_result.values_valid     = n_valid;
    end

    assign o_status.awaiting = r_await;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= hsps_pkg::PH_INIT;
            r_pend       <= 1'b1;
            r_due        <= TIME_BITS'(START_DELAY);
            r_ready      <= TIME_BITS'(START_DELAY);
            r_time       <= '0;
            r_ivl_left   <= '0;
            r_active     <= 1'b0;
            r_await      <= 1'b0;
            r_valid      <= 1'b0;
            r_hum        <= '0;
            r_temp       <= '0;
            r_dev_addr   <= hsps_pkg::RST_DEVICE_ADDRESS;
            r_interval   <= '0;
            r_init_delay <= hsps_pkg::RST_DELAY;
            r_meas_delay <= hsps_pkg::RST_DELAY;
        end else begin
            r_phase      <= n_phase;
            r_pend       <= n_pend;
            r_due        <= n_due;
            r_ready      <= n_ready;
            r_time       <= n_time;
            r_ivl_left   <= n_ivl_left;
            r_active     <= n_active;
            r_await      <= n_await;
            r_valid      <= n_valid;
            r_hum        <= n_hum;
            r_temp       <= n_temp;
            r_dev_addr   <= n_dev_addr;
            r_interval   <= n_interval;
            r_init_delay <= n_init_delay;
            r_meas_delay <= n_meas_delay;
        end
    end

endmodule

// ===== rtl/core/humidity_sensor_poll_sequencer.sv =====
// Top level of the humidity sensor poll sequencer: input register, core and result register.
// Depends on hsps_pkg, hsps_in_stage, hsps_seq_core and the assertion macro header.
//
// Each input transaction (tick, measure request or bus transfer outcome) yields exactly one
// result transaction. The block takes one transaction per clock while the output side does
// not stall. The input register holds each transaction while one pass through the sequencer
// logic computes the result, which is loaded into the result register when the transaction
// fires. The core reads and writes the sequencer registers once per transaction, so its
// state update sets the throughput. A result held by a stall
// on the output side blocks the core, and the input side then stalls as soon as the input
// register holds a transaction. Configuration writes are to be made only while no
// transaction is in flight.
module humidity_sensor_poll_sequencer #(
    parameter int TIME_BITS   = 32,
    parameter int START_DELAY = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_command,
    input  logic                             i_transfer_ok,
    input  logic [47:0]                      i_read_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_bus_request,
    output logic [6:0]                       o_bus_address,
    output logic [15:0]                      o_bus_write_word,
    output logic [1:0]                       o_event_code,
    output logic                             o_request_accepted,
    output logic [15:0]                      o_humidity_raw,
    output logic [15:0]                      o_temperature_raw,
    output logic                             o_values_valid,
    input  logic                             i_cfg_we,
    input  logic [hsps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hsps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

`include "humidity_sensor_poll_sequencer_assert.svh"

    hsps_pkg::t_item   in_item;
    hsps_pkg::t_item   held_item;
    logic              held_valid;
    logic              out_ready;
    logic              fire;
    hsps_pkg::t_result result;
    hsps_pkg::t_status status;

    logic              r_out_valid;
    hsps_pkg::t_result r_out;

    assign in_item.command     = i_command;
    assign in_item.transfer_ok = i_transfer_ok;
    assign in_item.read_data   = i_read_data;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign fire      = held_valid && out_ready;

    hsps_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_advance (out_ready),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    hsps_seq_core #(
        .TIME_BITS   (TIME_BITS),
        .START_DELAY (START_DELAY)
    ) u_seq_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (held_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result),
        .o_status    (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_bus_request      = r_out.bus_request;
    assign o_bus_address      = r_out.bus_address;
    assign o_bus_write_word   = r_out.bus_write_word;
    assign o_event_code       = r_out.event_code;
    assign o_request_accepted = r_out.request_accepted;
    assign o_humidity_raw     = r_out.humidity_raw;
    assign o_temperature_raw  = r_out.temperature_raw;
    assign o_values_valid     = r_out.values_valid;

    `HSPS_ASSERT_NOW(a_one_action,
        o_out_valid && o_bus_request != hsps_pkg::REQ_NONE,
        o_event_code == hsps_pkg::EV_NONE && !o_request_accepted,
        "bus request and event in one result")
    `HSPS_ASSERT_NOW(a_error_invalid,
        o_out_valid && o_event_code == hsps_pkg::EV_ERROR,
        !o_values_valid,
        "error result shows valid values")
    `HSPS_ASSERT_NEXT(a_xfer_clears,
        fire && held_item.command == hsps_pkg::CMD_XFER && status.awaiting && !i_cfg_we,
        !status.awaiting,
        "transfer outcome left the sequencer waiting")
    `HSPS_ASSERT_NEXT(a_held_item_kept,
        held_valid && !out_ready,
        held_valid,
        "stalled transaction dropped from input register")

endmodule

// ===== sim/humidity_sensor_poll_sequencer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the humidity sensor poll sequencer.
// Depends on hsps_pkg and humidity_sensor_poll_sequencer; an in-bench model of the
// sequencer predicts every result, and random idling on both channels stresses the handshakes.
module humidity_sensor_poll_sequencer_test;

    localparam int         TIME_W       = 32;
    localparam int         START_TICKS  = 20;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         STUCK_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         TICK_CAP     = 70000;

    logic                             clk            = 1'b0;
    logic                             rst_n          = 1'b0;
    logic                             in_valid       = 1'b0;
    logic                             in_stall;
    logic [1:0]                       in_command     = hsps_pkg::CMD_TICK;
    logic                             in_transfer_ok = 1'b0;
    logic [47:0]                      in_read_data   = '0;
    logic                             out_valid;
    logic                             out_stall      = 1'b0;
    logic [1:0]                       out_bus_request;
    logic [6:0]                       out_bus_address;
    logic [15:0]                      out_bus_write_word;
    logic [1:0]                       out_event_code;
    logic                             out_request_accepted;
    logic [15:0]                      out_humidity_raw;
    logic [15:0]                      out_temperature_raw;
    logic                             out_values_valid;
    logic                             cfg_we         = 1'b0;
    logic [hsps_pkg::CFG_INDEX_W-1:0] cfg_index      = hsps_pkg::CFG_DEVICE_ADDRESS;
    logic [hsps_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;

    int idle_pct  = 18;
    int stall_pct = 18;
    int failures  = 0;

    hsps_pkg::t_result expected_poll_results[$];
    hsps_pkg::t_result staged_result;
    logic              staged = 1'b0;

    // Sequencer model: configuration copy and state.
    logic [6:0]        dev_address;
    logic [31:0]       interval_ticks;
    logic [15:0]       init_ticks;
    logic [15:0]       measure_ticks;
    hsps_pkg::t_phase  seq_phase;
    logic              poll_pending;
    logic              poll_active;
    logic              xfer_outstanding;
    logic              readings_valid;
    logic [TIME_W-1:0] poll_due;
    logic [TIME_W-1:0] ready_at;
    logic [TIME_W-1:0] tick_count;
    logic [31:0]       interval_left;
    logic [15:0]       humidity_word;
    logic [15:0]       temperature_word;

    humidity_sensor_poll_sequencer #(
        .TIME_BITS  (TIME_W),
        .START_DELAY(START_TICKS)
    ) uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_command         (in_command),
        .i_transfer_ok     (in_transfer_ok),
        .i_read_data       (in_read_data),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_bus_request     (out_bus_request),
        .o_bus_address     (out_bus_address),
        .o_bus_write_word  (out_bus_write_word),
        .o_event_code      (out_event_code),
        .o_request_accepted(out_request_accepted),
        .o_humidity_raw    (out_humidity_raw),
        .o_temperature_raw (out_temperature_raw),
        .o_values_valid    (out_values_valid),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic void reset_sequencer_model();
        dev_address      = hsps_pkg::RST_DEVICE_ADDRESS;
        interval_ticks   = '0;
        init_ticks       = hsps_pkg::RST_DELAY;
        measure_ticks    = hsps_pkg::RST_DELAY;
        seq_phase        = hsps_pkg::PH_INIT;
        poll_pending     = 1'b1;
        poll_due         = TIME_W'(START_TICKS);
        ready_at         = TIME_W'(START_TICKS);
        tick_count       = '0;
        interval_left    = '0;
        poll_active      = 1'b0;
        xfer_outstanding = 1'b0;
        readings_valid   = 1'b0;
        humidity_word    = '0;
        temperature_word = '0;
    endfunction

    function automatic logic start_measurement();
        if (poll_active)
            return 1'b0;
        poll_active  = 1'b1;
        poll_pending = 1'b1;
        poll_due     = ready_at;
        return 1'b1;
    endfunction

    function automatic void apply_config(logic [1:0] index, logic [31:0] data);
        case (index)
            hsps_pkg::CFG_DEVICE_ADDRESS: dev_address = data[6:0];
            hsps_pkg::CFG_UPDATE_INTERVAL: begin
                interval_ticks = data;
                interval_left  = data;
                if (data != 32'd0)
                    void'(start_measurement());
            end
            hsps_pkg::CFG_INIT_DELAY:    init_ticks    = data[15:0];
            hsps_pkg::CFG_MEASURE_DELAY: measure_ticks = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic hsps_pkg::t_result predict_poll_result(logic [1:0] command, logic ok,
                                                              logic [47:0] data);
        hsps_pkg::t_result r;
        logic [TIME_W-1:0] since_due;
        r = '0;
        case (command)
            hsps_pkg::CMD_TICK: begin
                tick_count = tick_count + TIME_W'(1);
                if (interval_ticks != 32'd0) begin
                    if (interval_left <= 32'd1) begin
                        void'(start_measurement());
                        interval_left = interval_ticks;
                    end else begin
                        interval_left = interval_left - 32'd1;
                    end
                end
                // The due time counts as reached while the wrapped difference is non-negative.
                since_due = tick_count - poll_due;
                if (poll_pending && !xfer_outstanding && !since_due[TIME_W-1]) begin
                    case (seq_phase)
                        hsps_pkg::PH_INIT: begin
                            r.bus_request    = hsps_pkg::REQ_WRITE;
                            r.bus_write_word = hsps_pkg::SOFT_RESET_WORD;
                        end
                        hsps_pkg::PH_MEASURE: begin
                            r.bus_request    = hsps_pkg::REQ_WRITE;
                            r.bus_write_word = hsps_pkg::MEASURE_WORD;
                        end
                        hsps_pkg::PH_READ: r.bus_request = hsps_pkg::REQ_READ;
                        default: begin
                            poll_active  = 1'b0;
                            r.event_code = hsps_pkg::EV_UPDATE;
                            seq_phase    = hsps_pkg::PH_MEASURE;
                            poll_pending = 1'b0;
                        end
                    endcase
                    if (r.bus_request != hsps_pkg::REQ_NONE) begin
                        xfer_outstanding = 1'b1;
                        poll_pending     = 1'b0;
                    end
                end
            end
            hsps_pkg::CMD_MEASURE: r.request_accepted = start_measurement();
            hsps_pkg::CMD_XFER: begin
                if (xfer_outstanding) begin
                    xfer_outstanding = 1'b0;
                    if (!ok) begin
                        readings_valid = 1'b0;
                        poll_active    = 1'b0;
                        r.event_code   = hsps_pkg::EV_ERROR;
                        seq_phase      = hsps_pkg::PH_INIT;
                        poll_pending   = 1'b0;
                    end else if (seq_phase == hsps_pkg::PH_INIT) begin
                        seq_phase    = hsps_pkg::PH_MEASURE;
                        ready_at     = tick_count + TIME_W'(init_ticks);
                        poll_pending = poll_active;
                        if (poll_active)
                            poll_due = ready_at;
                    end else if (seq_phase == hsps_pkg::PH_MEASURE) begin
                        seq_phase    = hsps_pkg::PH_READ;
                        poll_pending = 1'b1;
                        poll_due     = tick_count + TIME_W'(measure_ticks);
                    end else begin
                        // Bytes 2 and 5 carry CRCs and are dropped.
                        temperature_word = data[47:32];
                        humidity_word    = data[23:8];
                        readings_valid   = 1'b1;
                        poll_active      = 1'b0;
                        r.event_code     = hsps_pkg::EV_UPDATE;
                        seq_phase        = hsps_pkg::PH_MEASURE;
                        poll_pending     = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (r.bus_request != hsps_pkg::REQ_NONE)
            r.bus_address = dev_address;
        r.humidity_raw    = humidity_word;
        r.temperature_raw = temperature_word;
        r.values_valid    = readings_valid;
        return r;
    endfunction

    function automatic logic [47:0] random_read_data();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    task automatic report_error(input string msg);
        if (failures < 100)
            $display("ERROR at %0t ns: %s", $time, msg);
        failures++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Expectations enter the queue at the falling edge after acceptance, so the checker
    // never sees a push and a pop in the same time step.
    task automatic commit_expectation();
        if (staged) begin
            expected_poll_results.push_back(staged_result);
            staged = 1'b0;
        end
    endtask

    task automatic send_item(input logic [1:0] command, input logic ok, input logic [47:0] data);
        @(negedge clk);
        commit_expectation();
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        in_command     <= command;
        in_transfer_ok <= ok;
        in_read_data   <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        staged_result = predict_poll_result(command, ok, data);
        staged        = 1'b1;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        commit_expectation();
        in_valid <= 1'b0;
        while (expected_poll_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_config(index, data);
    endtask

    // The interval goes last because a nonzero value starts a measurement on its own.
    task automatic set_config(input logic [6:0] address, input logic [31:0] interval,
                              input logic [15:0] init_delay_ticks,
                              input logic [15:0] meas_delay_ticks);
        wait_for_results();
        write_register(hsps_pkg::CFG_DEVICE_ADDRESS, {25'd0, address});
        write_register(hsps_pkg::CFG_INIT_DELAY, {16'd0, init_delay_ticks});
        write_register(hsps_pkg::CFG_MEASURE_DELAY, {16'd0, meas_delay_ticks});
        write_register(hsps_pkg::CFG_UPDATE_INTERVAL, interval);
    endtask

    task automatic tick_until_transfer();
        int n;
        n = 0;
        while (!xfer_outstanding && n < TICK_CAP) begin
            send_item(hsps_pkg::CMD_TICK, 1'($urandom_range(1)), random_read_data());
            n++;
        end
    endtask

    // Mostly well-formed polling: transfers are answered, measurements requested when idle,
    // and ticks fill the waits. A share of random transactions is mixed in as noise.
    task automatic run_polling(input int item_budget, input int noise_pct,
                               input logic stop_on_update);
        int r;
        for (int n = 0; n < item_budget; n++) begin
            r = $urandom_range(99);
            if (r < noise_pct)
                send_item(2'($urandom_range(3)), 1'($urandom_range(1)), random_read_data());
            else if (xfer_outstanding)
                send_item(hsps_pkg::CMD_XFER, $urandom_range(99) < 90, random_read_data());
            else if (!poll_active && r < noise_pct + 20)
                send_item(hsps_pkg::CMD_MEASURE, 1'($urandom_range(1)), random_read_data());
            else
                send_item(hsps_pkg::CMD_TICK, 1'($urandom_range(1)), random_read_data());
            if ($urandom_range(199) == 0)
                wait_for_results();
            if (stop_on_update && staged_result.event_code == hsps_pkg::EV_UPDATE)
                break;
        end
    endtask

    task automatic test_first_poll_with_defaults();
        send_item(CMD_UNUSED, 1'b1, '1);
        send_item(hsps_pkg::CMD_XFER, 1'b1, '1);
        send_item(hsps_pkg::CMD_MEASURE, 1'b0, '0);
        send_item(hsps_pkg::CMD_MEASURE, 1'b1, '1);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b1, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b1, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b1, '1);
    endtask

    task automatic test_transfer_failures();
        set_config(7'h7F, 32'd0, 16'd0, 16'd0);
        // Read fails.
        send_item(hsps_pkg::CMD_MEASURE, 1'b0, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b1, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b0, '1);
        // Soft reset fails.
        send_item(hsps_pkg::CMD_MEASURE, 1'b0, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b0, '0);
        // Measure command fails.
        send_item(hsps_pkg::CMD_MEASURE, 1'b0, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b1, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b0, '1);
        // Full poll that returns an all-zero reading.
        send_item(hsps_pkg::CMD_MEASURE, 1'b0, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b1, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b1, '0);
        tick_until_transfer();
        send_item(hsps_pkg::CMD_XFER, 1'b1, '0);
    endtask

    task automatic test_random_polling();
        set_config(7'($urandom_range(127)), 32'd0, 16'($urandom_range(6)),
                   16'($urandom_range(6)));
        run_polling(400, 10, 1'b0);
    endtask

    task automatic test_back_to_back();
        set_config(7'($urandom_range(127)), 32'd0, 16'd0, 16'd1);
        idle_pct  = 0;
        stall_pct = 0;
        run_polling(250, 10, 1'b0);
        idle_pct  = 18;
        stall_pct = 18;
    endtask

    task automatic test_periodic_requests();
        set_config(7'($urandom_range(127)), 32'd1, 16'd0, 16'd0);
        run_polling(150, 10, 1'b0);
        set_config(7'($urandom_range(127)), 32'($urandom_range(12, 2)),
                   16'($urandom_range(3)), 16'($urandom_range(3)));
        run_polling(250, 10, 1'b0);
    endtask

    task automatic test_extreme_settings();
        set_config(7'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        run_polling(100, 2, 1'b1);
        set_config(hsps_pkg::RST_DEVICE_ADDRESS, 32'd0, hsps_pkg::RST_DELAY,
                   hsps_pkg::RST_DELAY);
        run_polling(60, 10, 1'b0);
    endtask

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin : result_check
        hsps_pkg::t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_poll_results.size() == 0) begin
                report_error("result transaction with none outstanding");
            end else begin
                want = expected_poll_results.pop_front();
                compare_field("bus_request", 16'(out_bus_request), 16'(want.bus_request));
                compare_field("bus_address", 16'(out_bus_address), 16'(want.bus_address));
                compare_field("bus_write_word", out_bus_write_word, want.bus_write_word);
                compare_field("event_code", 16'(out_event_code), 16'(want.event_code));
                compare_field("request_accepted", 16'(out_request_accepted),
                              16'(want.request_accepted));
                compare_field("humidity_raw", out_humidity_raw, want.humidity_raw);
                compare_field("temperature_raw", out_temperature_raw, want.temperature_raw);
                compare_field("values_valid", 16'(out_values_valid), 16'(want.values_valid));
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        reset_sequencer_model();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_first_poll_with_defaults();
        test_transfer_failures();
        test_random_polling();
        test_back_to_back();
        test_periodic_requests();
        test_extreme_settings();
        wait_for_results();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hsps_pkg.sv
rtl/core/hsps_in_stage.sv
rtl/core/hsps_seq_core.sv
rtl/core/humidity_sensor_poll_sequencer.sv
sim/humidity_sensor_poll_sequencer_test.sv
